/* rtl/lom_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lom_pkg;
    localparam logic [2:0] KIND_TRADE     = 3'd0;
    localparam logic [2:0] KIND_RESTED    = 3'd1;
    localparam logic [2:0] KIND_DONE      = 3'd2;
    localparam logic [2:0] KIND_CANCELLED = 3'd3;
    localparam logic [2:0] KIND_NOTFOUND  = 3'd4;
    localparam logic [2:0] KIND_FULL      = 3'd5;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;

    localparam int ID_W    = 16;
    localparam int PRICE_W = 20;
    localparam int QTY_W   = 20;
    localparam int ARR_W   = 32;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [ARR_W-1:0]   arrival;
    } entry_t;
endpackage
`default_nettype wire

/* rtl/lom_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/limit_order_matcher.sv */
// Price-time priority order book over MAX_ORDERS table slots. Assert start
// for one cycle while busy is low; busy then stays high until the item is
// finished. Every result appears for a single cycle with strobe high and
// cannot be stalled; the closing status result carries last=1. The table is
// scanned one slot per cycle through a registered-read RAM: a cancel scans
// every slot, the free-slot search checks slots in order until it finds a
// free one, and each fill costs one best-price scan followed by a fill step.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_matcher
    import lom_pkg::*;
#(
    parameter int MAX_ORDERS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cmd,
    input  wire logic [ID_W-1:0]    order_id,
    input  wire logic               side,
    input  wire logic [PRICE_W-1:0] limit_price,
    input  wire logic [QTY_W-1:0]   quantity,
    output logic                    strobe,
    output logic [2:0]              kind,
    output logic [ID_W-1:0]         buyer_id,
    output logic [ID_W-1:0]         seller_id,
    output logic [PRICE_W-1:0]      trade_price,
    output logic [QTY_W-1:0]        trade_qty,
    output logic                    last
);
    localparam int AW = $clog2(MAX_ORDERS);
    localparam int CW = AW + 1;
    localparam int EW = $bits(entry_t);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_ORDERS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CANCEL = 3'd1;
    localparam logic [2:0] S_BEST   = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_FREE   = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       ridx_reg, ridx_next;
    logic                rvalid_reg, rvalid_next;
    logic [AW-1:0]       didx_reg, didx_next;
    logic                dvalid_reg, dvalid_next;
    logic [MAX_ORDERS-1:0] valid_reg, valid_next;
    logic [ARR_W-1:0]    arr_ctr_reg, arr_ctr_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                side_reg, side_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [QTY_W-1:0]    qty_reg, qty_next;
    logic                hit_reg, hit_next;
    logic [AW-1:0]       best_reg, best_next;
    entry_t              best_e_reg, best_e_next;
    logic [2:0]          status_reg, status_next;

    logic                strobe_reg, strobe_next;
    logic [2:0]          kind_reg, kind_next;
    logic [ID_W-1:0]     buyer_reg, buyer_next;
    logic [ID_W-1:0]     seller_reg, seller_next;
    logic [PRICE_W-1:0]  tprice_reg, tprice_next;
    logic [QTY_W-1:0]    tqty_reg, tqty_next;
    logic                last_reg, last_next;

    logic                we;
    logic [AW-1:0]       waddr;
    entry_t              wdata;
    entry_t              rd;
    logic [EW-1:0]       rd_bits;
    logic                slot_ok;
    logic                better;
    logic                crosses;
    logic [QTY_W-1:0]    fill;

    lom_ram #(.WIDTH(EW), .DEPTH(MAX_ORDERS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ridx_reg),
        .rdata (rd_bits)
    );
    assign rd = entry_t'(rd_bits);

    assign slot_ok = dvalid_reg && valid_reg[didx_reg];

    always_comb
    begin
        if (rd.price != best_e_reg.price)
        begin
            better = side_reg ? (rd.price > best_e_reg.price)
                              : (rd.price < best_e_reg.price);
        end
        else
        begin
            better = rd.arrival < best_e_reg.arrival;
        end
        crosses = (price_reg == '0) ||
                  (side_reg == 1'b0 && best_e_reg.price <= price_reg) ||
                  (side_reg == 1'b1 && best_e_reg.price >= price_reg);
        fill = (qty_reg < best_e_reg.qty) ? qty_reg : best_e_reg.qty;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ridx_next    = ridx_reg;
        rvalid_next  = 1'b0;
        didx_next    = ridx_reg;
        dvalid_next  = rvalid_reg;
        valid_next   = valid_reg;
        arr_ctr_next = arr_ctr_reg;
        id_next      = id_reg;
        side_next    = side_reg;
        price_next   = price_reg;
        qty_next     = qty_reg;
        hit_next     = hit_reg;
        best_next    = best_reg;
        best_e_next  = best_e_reg;
        status_next  = status_reg;
        strobe_next  = 1'b0;
        kind_next    = kind_reg;
        buyer_next   = '0;
        seller_next  = '0;
        tprice_next  = '0;
        tqty_next    = '0;
        last_next    = 1'b0;
        we           = 1'b0;
        waddr        = best_reg;
        wdata        = best_e_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    id_next    = order_id;
                    side_next  = side;
                    price_next = limit_price;
                    qty_next   = quantity;
                    hit_next   = 1'b0;
                    cnt_next   = '0;
                    ridx_next  = '0;
                    if (cmd == CMD_CANCEL)
                    begin
                        rvalid_next = 1'b1;
                        state_next  = S_CANCEL;
                    end
                    else if (quantity == '0)
                    begin
                        status_next = KIND_DONE;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        rvalid_next = 1'b1;
                        state_next  = S_BEST;
                    end
                end
            end
            S_CANCEL:
            begin
                if (cnt_reg < LAST_IDX)
                begin
                    ridx_next   = AW'(cnt_reg + 1'b1);
                    rvalid_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (slot_ok && rd.id == id_reg &&
                    (!hit_reg || rd.arrival < best_e_reg.arrival))
                begin
                    hit_next    = 1'b1;
                    best_next   = didx_reg;
                    best_e_next = rd;
                end
                if (dvalid_reg && didx_reg == AW'(LAST_IDX))
                begin
                    state_next = S_EMIT;
                    if (hit_next)
                    begin
                        valid_next[best_next] = 1'b0;
                        status_next = KIND_CANCELLED;
                    end
                    else
                    begin
                        status_next = KIND_NOTFOUND;
                    end
                end
            end
            S_BEST:
            begin
                if (cnt_reg < LAST_IDX)
                begin
                    ridx_next   = AW'(cnt_reg + 1'b1);
                    rvalid_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (slot_ok && rd.side != side_reg && (!hit_reg || better))
                begin
                    hit_next    = 1'b1;
                    best_next   = didx_reg;
                    best_e_next = rd;
                end
                if (dvalid_reg && didx_reg == AW'(LAST_IDX))
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (hit_reg && crosses)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_TRADE;
                    buyer_next  = side_reg ? best_e_reg.id : id_reg;
                    seller_next = side_reg ? id_reg : best_e_reg.id;
                    tprice_next = best_e_reg.price;
                    tqty_next   = fill;
                    qty_next    = qty_reg - fill;
                    we          = 1'b1;
                    wdata       = best_e_reg;
                    wdata.qty   = best_e_reg.qty - fill;
                    if (best_e_reg.qty == fill)
                    begin
                        valid_next[best_reg] = 1'b0;
                    end
                    hit_next  = 1'b0;
                    cnt_next  = '0;
                    ridx_next = '0;
                    if (qty_reg == fill)
                    begin
                        status_next = KIND_DONE;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        rvalid_next = 1'b1;
                        state_next  = S_BEST;
                    end
                end
                else if (price_reg == '0)
                begin
                    status_next = KIND_DONE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                if (!valid_reg[cnt_reg[AW-1:0]])
                begin
                    we                 = 1'b1;
                    waddr              = cnt_reg[AW-1:0];
                    wdata.id           = id_reg;
                    wdata.side         = side_reg;
                    wdata.price        = price_reg;
                    wdata.qty          = qty_reg;
                    wdata.arrival      = arr_ctr_reg;
                    valid_next[cnt_reg[AW-1:0]] = 1'b1;
                    arr_ctr_next       = arr_ctr_reg + 1'b1;
                    status_next        = KIND_RESTED;
                    state_next         = S_EMIT;
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    status_next = KIND_FULL;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                strobe_next = 1'b1;
                kind_next   = status_reg;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            arr_ctr_reg <= '0;
            rvalid_reg  <= 1'b0;
            dvalid_reg  <= 1'b0;
            didx_reg    <= '0;
            strobe_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            cnt_reg     <= '0;
            ridx_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            arr_ctr_reg <= arr_ctr_next;
            rvalid_reg  <= rvalid_next;
            dvalid_reg  <= dvalid_next;
            didx_reg    <= didx_next;
            strobe_reg  <= strobe_next;
            hit_reg     <= hit_next;
            cnt_reg     <= cnt_next;
            ridx_reg    <= ridx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        side_reg   <= side_next;
        price_reg  <= price_next;
        qty_reg    <= qty_next;
        best_reg   <= best_next;
        best_e_reg <= best_e_next;
        status_reg <= status_next;
        kind_reg   <= kind_next;
        buyer_reg  <= buyer_next;
        seller_reg <= seller_next;
        tprice_reg <= tprice_next;
        tqty_reg   <= tqty_next;
        last_reg   <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign kind        = kind_reg;
    assign buyer_id    = buyer_reg;
    assign seller_id   = seller_reg;
    assign trade_price = tprice_reg;
    assign trade_qty   = tqty_reg;
    assign last        = last_reg;
endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import lom_pkg::*;

    localparam int SLOTS = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int EXP_DEPTH = 128;

    typedef struct packed {
        logic [2:0]         kind;
        logic [ID_W-1:0]    buyer;
        logic [ID_W-1:0]    seller;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic               last;
    } fill_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cmd;
    logic [ID_W-1:0] order_id;
    logic side;
    logic [PRICE_W-1:0] limit_price;
    logic [QTY_W-1:0] quantity;
    logic strobe;
    logic [2:0] kind;
    logic [ID_W-1:0] buyer_id;
    logic [ID_W-1:0] seller_id;
    logic [PRICE_W-1:0] trade_price;
    logic [QTY_W-1:0] trade_qty;
    logic last;

    bit              book_live [SLOTS];
    logic [ID_W-1:0] book_id [SLOTS];
    logic            book_side [SLOTS];
    logic [PRICE_W-1:0] book_price [SLOTS];
    logic [QTY_W-1:0] book_qty [SLOTS];
    logic [31:0]     book_stamp [SLOTS];
    logic [31:0]     stamp_next;

    fill_t exp_buf [EXP_DEPTH];
    int exp_wr;
    int exp_rd;
    int errors;
    int idle_cycles;
    bit hold_gaps;

    limit_order_matcher #(.MAX_ORDERS(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .order_id(order_id), .side(side), .limit_price(limit_price),
        .quantity(quantity), .strobe(strobe), .kind(kind), .buyer_id(buyer_id),
        .seller_id(seller_id), .trade_price(trade_price), .trade_qty(trade_qty),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic fill_t make_fill(logic [2:0] k, logic [ID_W-1:0] b,
                                        logic [ID_W-1:0] s, logic [PRICE_W-1:0] p,
                                        logic [QTY_W-1:0] q, logic l);
        fill_t f;
        f.kind = k; f.buyer = b; f.seller = s; f.price = p; f.qty = q; f.last = l;
        return f;
    endfunction

    task automatic expect_result(fill_t f);
        exp_buf[exp_wr % EXP_DEPTH] = f;
        exp_wr++;
    endtask

    function automatic int best_resting(logic want);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!book_live[i] || book_side[i] != want)
                continue;
            if (best < 0)
                best = i;
            else if (book_price[i] != book_price[best])
            begin
                if (want ? book_price[i] < book_price[best]
                         : book_price[i] > book_price[best])
                    best = i;
            end
            else if (book_stamp[i] < book_stamp[best])
                best = i;
        end
        return best;
    endfunction

    task automatic match_order(logic c, logic [ID_W-1:0] id, logic sd,
                               logic [PRICE_W-1:0] lim, logic [QTY_W-1:0] q);
        int hit;
        int b;
        logic [QTY_W-1:0] fill;
        if (c == CMD_CANCEL)
        begin
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (book_live[i] && book_id[i] == id &&
                    (hit < 0 || book_stamp[i] < book_stamp[hit]))
                    hit = i;
            if (hit < 0)
                expect_result(make_fill(KIND_NOTFOUND, '0, '0, '0, '0, 1'b1));
            else
            begin
                book_live[hit] = 1'b0;
                expect_result(make_fill(KIND_CANCELLED, '0, '0, '0, '0, 1'b1));
            end
            return;
        end
        while (q != '0)
        begin
            b = best_resting(~sd);
            if (b < 0)
                break;
            if (lim != '0 && (sd == 1'b0 ? book_price[b] > lim : book_price[b] < lim))
                break;
            fill = (q < book_qty[b]) ? q : book_qty[b];
            if (sd == 1'b0)
                expect_result(make_fill(KIND_TRADE, id, book_id[b],
                                        book_price[b], fill, 1'b0));
            else
                expect_result(make_fill(KIND_TRADE, book_id[b], id,
                                        book_price[b], fill, 1'b0));
            q -= fill;
            book_qty[b] -= fill;
            if (book_qty[b] == '0)
                book_live[b] = 1'b0;
        end
        if (q == '0 || lim == '0)
        begin
            expect_result(make_fill(KIND_DONE, '0, '0, '0, '0, 1'b1));
            return;
        end
        for (int i = 0; i < SLOTS; i++)
            if (!book_live[i])
            begin
                book_live[i] = 1'b1;
                book_id[i] = id;
                book_side[i] = sd;
                book_price[i] = lim;
                book_qty[i] = q;
                book_stamp[i] = stamp_next;
                stamp_next++;
                expect_result(make_fill(KIND_RESTED, '0, '0, '0, '0, 1'b1));
                return;
            end
        expect_result(make_fill(KIND_FULL, '0, '0, '0, '0, 1'b1));
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic random_gap();
        int n;
        if (hold_gaps)
            return;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        repeat (n) @(negedge clk);
    endtask

    task automatic send_beat(logic c, logic [ID_W-1:0] id, logic sd,
                             logic [PRICE_W-1:0] lim, logic [QTY_W-1:0] q);
        random_gap();
        @(negedge clk);
        while (busy)
            @(negedge clk);
        cmd <= c;
        order_id <= id;
        side <= sd;
        limit_price <= lim;
        quantity <= q;
        start <= 1'b1;
        @(posedge clk);
        match_order(c, id, sd, lim, q);
        @(negedge clk);
        start <= 1'b0;
        cmd <= 1'($urandom());
        order_id <= 16'($urandom());
        side <= 1'($urandom());
        limit_price <= 20'($urandom());
        quantity <= 20'($urandom());
    endtask

    task automatic drain_results();
        while (exp_wr != exp_rd)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        fill_t want;
        if (rst_n && strobe)
        begin
            if (exp_wr == exp_rd)
                report_mismatch("result with nothing expected");
            else
            begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d want %0d", kind, want.kind));
                if (buyer_id !== want.buyer)
                    report_mismatch($sformatf("buyer %0h want %0h", buyer_id, want.buyer));
                if (seller_id !== want.seller)
                    report_mismatch($sformatf("seller %0h want %0h",
                                              seller_id, want.seller));
                if (trade_price !== want.price)
                    report_mismatch($sformatf("price %0h want %0h",
                                              trade_price, want.price));
                if (trade_qty !== want.qty)
                    report_mismatch($sformatf("qty %0h want %0h", trade_qty, want.qty));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b want %0b", last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_edges();
        send_beat(CMD_CANCEL, 16'hFFFF, 1'b0, '0, '0);
        send_beat(CMD_ADD, 16'h0001, 1'b0, 20'hFFFFF, '0);
        send_beat(CMD_ADD, 16'h0002, 1'b1, '0, 20'd5);
        send_beat(CMD_ADD, 16'h0003, 1'b1, 20'd100, 20'hFFFFF);
        send_beat(CMD_ADD, 16'h0004, 1'b1, 20'd100, 20'd7);
        send_beat(CMD_ADD, 16'h0005, 1'b1, 20'd90, 20'd3);
        send_beat(CMD_ADD, 16'h0006, 1'b0, 20'd100, 20'd10);
        send_beat(CMD_ADD, 16'h0007, 1'b0, 20'd50, 20'd4);
        send_beat(CMD_ADD, 16'h0008, 1'b1, 20'd40, 20'd2);
        send_beat(CMD_ADD, 16'h0009, 1'b1, '0, 20'hFFFFF);
        send_beat(CMD_ADD, 16'h0003, 1'b1, 20'd200, 20'd1);
        send_beat(CMD_CANCEL, 16'h0003, 1'b1, '0, '0);
        send_beat(CMD_CANCEL, 16'h0003, 1'b0, 20'hFFFFF, 20'hFFFFF);
        send_beat(CMD_ADD, 16'h0000, 1'b0, '0, 20'hFFFFF);
        send_beat(CMD_CANCEL, 16'h0003, 1'b0, '0, '0);
    endtask

    task automatic test_full_book();
        for (int i = 0; i < SLOTS + 2; i++)
            send_beat(CMD_ADD, 16'(16'h100 + i), 1'b1, 20'(1000 + (i % 5)), 20'd2);
        send_beat(CMD_ADD, 16'h0200, 1'b0, 20'd1002, 20'd5);
        send_beat(CMD_ADD, 16'h0201, 1'b0, 20'hFFFFF, 20'hFFFFF);
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [ID_W-1:0] id;
        logic [PRICE_W-1:0] p;
        logic [QTY_W-1:0] q;
        for (int n = 0; n < count; n++)
        begin
            hold_gaps = ($urandom_range(0, 3) == 0);
            id = (n % 10 == 9) ? 16'($urandom()) : 16'($urandom_range(0, 40));
            if ($urandom_range(0, 19) == 0)
                p = ($urandom_range(0, 1) != 0) ? 20'hFFFFF : 20'($urandom());
            else if ($urandom_range(0, 9) == 0)
                p = '0;
            else
                p = 20'($urandom_range(990, 1010));
            q = ($urandom_range(0, 19) == 0) ? 20'($urandom())
                                               : 20'($urandom_range(0, 30));
            if ($urandom_range(0, 4) == 0)
                send_beat(CMD_CANCEL, id, 1'($urandom()), 20'($urandom()),
                          20'($urandom()));
            else
                send_beat(CMD_ADD, id, 1'($urandom()), p, q);
            if (n == count / 2)
                drain_results();
        end
        hold_gaps = 1'b0;
    endtask

    initial
    begin
        errors = 0;
        exp_wr = 0;
        exp_rd = 0;
        hold_gaps = 1'b0;
        stamp_next = '0;
        for (int i = 0; i < SLOTS; i++)
            book_live[i] = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = 1'b0;
        order_id = '0;
        side = 1'b0;
        limit_price = '0;
        quantity = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edges();
        test_full_book();
        test_random(320);

        drain_results();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* filelist.f */
rtl/lom_pkg.sv
rtl/lom_ram.sv
rtl/limit_order_matcher.sv
verif/tb_top.sv
